// File: hdl/nfid_pkg.sv
// Shared constants and codes for the next-fit id allocator.
// Used by hdl/next_fit_id_allocator.sv; no dependencies.
package nfid_pkg;

    localparam int ID_SLOTS      = 256;
    localparam int ID_W          = 8;
    localparam int HANDLE_W      = 16;
    localparam int CNT_W         = 9;
    localparam int FIRST_USER_ID = 2;
    localparam int KERNEL_ID     = 1;

    // bitmap memory geometry: one row holds WORD_W in-use flags
    localparam int WORD_W = 64;
    localparam int ROWS   = ID_SLOTS / WORD_W;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int STEP_W = $clog2(ROWS + 1);

    localparam int S_TDATA_W = 24;  // target_id, owner_handle
    localparam int M_TDATA_W = 40;  // result_id, result_handle, live_count, pad

    typedef enum logic [1:0] {
        FN_ALLOC   = 2'd0,
        FN_RELEASE = 2'd1,
        FN_LOOKUP  = 2'd2,
        FN_NOP     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_BAD_RELEASE = 2'd2,
        ST_NOT_FOUND   = 2'd3
    } t_status;

endpackage

// File: hdl/next_fit_id_allocator.sv
// Sequence: a release or lookup beat passes through S_RELEASE or S_LOOKUP, then S_RESP; a no-op
// goes straight to S_RESP; an allocate searches in S_ALLOC, one bitmap row read per search cycle.
// Throughput: one item at a time; the next beat is taken once the result has moved to the
// output register, which S_RESP loads only when it is empty or being taken.
// Reset (i_rst_n low, synchronous): only the kernel id in use, cursor at the first user id,
// live count 1; unwritten bitmap rows read as reset values via row flags. Uses nfid_pkg.
module next_fit_id_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [nfid_pkg::S_TDATA_W-1:0]   i_s_tdata,   // [7:0] target_id, [23:8] owner_handle
    input  logic [1:0]                       i_s_tuser,   // [1:0] func
    // result channel
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [nfid_pkg::M_TDATA_W-1:0]   o_m_tdata,   // [7:0] result_id, [23:8] result_handle,
                                                          // [32:24] live_count, [39:33] zero
    output logic [1:0]                       o_m_tuser    // [1:0] status
);

    localparam int ID_W     = nfid_pkg::ID_W;
    localparam int HANDLE_W = nfid_pkg::HANDLE_W;
    localparam int CNT_W    = nfid_pkg::CNT_W;
    localparam int WORD_W   = nfid_pkg::WORD_W;
    localparam int ROW_W    = nfid_pkg::ROW_W;
    localparam int BIT_W    = nfid_pkg::BIT_W;
    localparam int STEP_W   = nfid_pkg::STEP_W;
    localparam int ROWS     = nfid_pkg::ROWS;
    localparam int PAD_W    = nfid_pkg::M_TDATA_W - ID_W - HANDLE_W - CNT_W;

    localparam logic [WORD_W-1:0] KERNEL_ROW = WORD_W'(1) << nfid_pkg::KERNEL_ID;
    // ids below the first user id never take part in the search
    localparam logic [WORD_W-1:0] LOW_IDS = (WORD_W'(1) << nfid_pkg::FIRST_USER_ID) - 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_RELEASE,
        S_LOOKUP,
        S_RESP
    } t_state;

    // ---------------- memories ----------------
    // in-use bitmap: ROWS x WORD_W, one read and one write port, registered read
    logic [WORD_W-1:0]   r_bitmap [ROWS];
    logic [ROWS-1:0]     r_row_vld;       // row written since reset
    logic [WORD_W-1:0]   r_bm_q;
    logic                r_bm_q_vld;
    logic [ROW_W-1:0]    r_rd_row;        // row whose data sits in r_bm_q

    // owner handles: ID_SLOTS x HANDLE_W, registered read, never cleared
    logic [HANDLE_W-1:0] r_owner [nfid_pkg::ID_SLOTS];
    logic [HANDLE_W-1:0] r_own_q;

    logic                bm_re;
    logic [ROW_W-1:0]    bm_raddr;
    logic                bm_we;
    logic [ROW_W-1:0]    bm_waddr;
    logic [WORD_W-1:0]   bm_wdata;
    logic                own_re;
    logic [ID_W-1:0]     own_raddr;
    logic                own_we;
    logic [ID_W-1:0]     own_waddr;

    // ---------------- control registers ----------------
    t_state               r_state, n_state;
    logic [ID_W-1:0]      r_cursor, n_cursor;
    logic [CNT_W-1:0]     r_live, n_live;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [ID_W-1:0]      r_tid, n_tid;
    logic [HANDLE_W-1:0]  r_handle, n_handle;
    nfid_pkg::t_status    r_res_status, n_res_status;
    logic [ID_W-1:0]      r_res_id, n_res_id;
    logic [HANDLE_W-1:0]  r_res_handle, n_res_handle;
    logic                 r_m_tvalid, n_m_tvalid;
    logic [nfid_pkg::M_TDATA_W-1:0] r_m_tdata, n_m_tdata;
    logic [1:0]           r_m_tuser, n_m_tuser;

    // ---------------- datapath ----------------
    logic                 s_beat;
    nfid_pkg::t_func      in_func;
    logic [ID_W-1:0]      in_tid;
    logic [WORD_W-1:0]    rd_word;
    logic [WORD_W-1:0]    hi_mask;
    logic [WORD_W-1:0]    allow;
    logic [WORD_W-1:0]    free_bits;
    logic                 found;
    logic [BIT_W-1:0]     free_pos;
    logic [ID_W-1:0]      found_id;
    logic [ID_W:0]        id_plus;
    logic [ID_W-1:0]      next_cursor;
    logic [BIT_W-1:0]     tid_bit;
    logic                 tid_used;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_beat     = i_s_tvalid && o_s_tready;
    assign in_func    = nfid_pkg::t_func'(i_s_tuser);
    assign in_tid     = i_s_tdata[ID_W-1:0];

    // unwritten rows read as their reset value
    assign rd_word = r_bm_q_vld ? r_bm_q :
                     ((r_rd_row == '0) ? KERNEL_ROW : '0);

    // search window: from the cursor bit on the first row, all bits on middle rows,
    // and below the cursor bit when the scan comes back to the starting row
    assign hi_mask = {WORD_W{1'b1}} << r_cursor[BIT_W-1:0];

    always_comb begin
        if (r_step == '0) begin
            allow = hi_mask;
        end else if (r_step == STEP_W'(ROWS)) begin
            allow = ~hi_mask;
        end else begin
            allow = '1;
        end
        if (r_rd_row == '0) begin
            allow = allow & ~LOW_IDS;
        end
    end

    assign free_bits = ~rd_word & allow;

    // lowest free bit in the row
    always_comb begin
        free_pos = '0;
        found    = 1'b0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                free_pos = BIT_W'(i);
                found    = 1'b1;
            end
        end
    end

    assign found_id = {r_rd_row, free_pos};
    assign id_plus  = {1'b0, found_id} + 1'b1;
    assign next_cursor = (id_plus >= (ID_W+1)'(nfid_pkg::ID_SLOTS)) ?
                         ID_W'(nfid_pkg::FIRST_USER_ID) : id_plus[ID_W-1:0];

    assign tid_bit  = r_tid[BIT_W-1:0];
    assign tid_used = rd_word[tid_bit];

    // ---------------- next-state logic ----------------
    always_comb begin
        n_state      = r_state;
        n_cursor     = r_cursor;
        n_live       = r_live;
        n_step       = r_step;
        n_tid        = r_tid;
        n_handle     = r_handle;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_handle = r_res_handle;
        n_m_tvalid   = r_m_tvalid && !i_m_tready;
        n_m_tdata    = r_m_tdata;
        n_m_tuser    = r_m_tuser;

        bm_re     = 1'b0;
        bm_raddr  = r_cursor[ID_W-1 -: ROW_W];
        bm_we     = 1'b0;
        bm_waddr  = r_rd_row;
        bm_wdata  = rd_word;
        own_re    = 1'b0;
        own_raddr = in_tid;
        own_we    = 1'b0;
        own_waddr = found_id;

        case (r_state)
            S_IDLE: begin
                if (s_beat) begin
                    n_tid        = in_tid;
                    n_handle     = i_s_tdata[ID_W +: HANDLE_W];
                    n_step       = '0;
                    n_res_status = nfid_pkg::ST_OK;
                    n_res_id     = in_tid;
                    n_res_handle = '0;
                    case (in_func)
                        nfid_pkg::FN_ALLOC: begin
                            bm_re   = 1'b1;
                            n_state = S_ALLOC;
                        end
                        nfid_pkg::FN_RELEASE: begin
                            bm_re    = 1'b1;
                            bm_raddr = in_tid[ID_W-1 -: ROW_W];
                            n_state  = S_RELEASE;
                        end
                        nfid_pkg::FN_LOOKUP: begin
                            bm_re    = 1'b1;
                            bm_raddr = in_tid[ID_W-1 -: ROW_W];
                            own_re   = 1'b1;
                            n_state  = S_LOOKUP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            // one row per cycle; the next row read is issued while this one is checked
            S_ALLOC: begin
                if (found) begin
                    bm_we        = 1'b1;
                    bm_wdata     = rd_word | (WORD_W'(1) << free_pos);
                    own_we       = 1'b1;
                    n_live       = r_live + 1'b1;
                    n_cursor     = next_cursor;
                    n_res_id     = found_id;
                    n_state      = S_RESP;
                end else if (r_step == STEP_W'(ROWS)) begin
                    n_res_status = nfid_pkg::ST_FULL;
                    n_res_id     = '0;
                    n_state      = S_RESP;
                end else begin
                    bm_re    = 1'b1;
                    bm_raddr = r_rd_row + 1'b1;
                    n_step   = r_step + 1'b1;
                end
            end

            S_RELEASE: begin
                if (r_tid >= ID_W'(nfid_pkg::FIRST_USER_ID) && tid_used) begin
                    bm_we    = 1'b1;
                    bm_wdata = rd_word & ~(WORD_W'(1) << tid_bit);
                    n_live   = r_live - 1'b1;
                    n_cursor = r_tid;
                end else begin
                    n_res_status = nfid_pkg::ST_BAD_RELEASE;
                end
                n_state = S_RESP;
            end

            S_LOOKUP: begin
                if (r_tid >= ID_W'(nfid_pkg::KERNEL_ID) && tid_used) begin
                    n_res_handle = r_own_q;
                end else begin
                    n_res_status = nfid_pkg::ST_NOT_FOUND;
                end
                n_state = S_RESP;
            end

            S_RESP: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {{PAD_W{1'b0}}, r_live, r_res_handle, r_res_id};
                    n_m_tuser  = r_res_status;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------- state and output registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cursor   <= ID_W'(nfid_pkg::FIRST_USER_ID);
            r_live     <= CNT_W'(1);
            r_step     <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cursor   <= n_cursor;
            r_live     <= n_live;
            r_step     <= n_step;
            r_m_tvalid <= n_m_tvalid;
        end
        r_tid        <= n_tid;
        r_handle     <= n_handle;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_handle <= n_res_handle;
        r_m_tdata    <= n_m_tdata;
        r_m_tuser    <= n_m_tuser;
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    // ---------------- bitmap memory ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (bm_we) begin
            r_row_vld[bm_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            r_bitmap[bm_waddr] <= bm_wdata;
        end
        if (bm_re) begin
            r_bm_q     <= r_bitmap[bm_raddr];
            r_bm_q_vld <= r_row_vld[bm_raddr];
            r_rd_row   <= bm_raddr;
        end
    end

    // ---------------- owner memory ----------------
    always_ff @(posedge i_clk) begin
        if (own_we) begin
            r_owner[own_waddr] <= r_handle;
        end
        if (own_re) begin
            r_own_q <= r_owner[own_raddr];
        end
    end

endmodule
